// File: hdl/mie_pkg.sv
package mie_pkg;

	localparam int REG_NUM_W = 5;
	localparam int DATA_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int OFFS_W    = 16;
	localparam int TGT_W     = 8;
	localparam int IDX_OUT_W = 8;
	localparam int DADDR_W   = 16;   // enough for the largest data memory
	localparam int TGT_SPAN  = 2 ** TGT_W;

	typedef enum logic [2:0] {
		FN_LB   = 3'd0,
		FN_SB   = 3'd1,
		FN_ADD  = 3'd2,
		FN_ADDI = 3'd3,
		FN_BNZ  = 3'd4
	} func_t;

	typedef struct packed {
		logic                 en;
		logic [REG_NUM_W-1:0] addr;
		logic [DATA_W-1:0]    data;
	} rf_wr_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [DADDR_W-1:0] addr;
		logic [BYTE_W-1:0]  wdata;
	} dm_req_t;

	function automatic logic [DATA_W-1:0] sext8(input logic [BYTE_W-1:0] b);
		return {{(DATA_W-BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

	function automatic logic [DATA_W-1:0] sext16(input logic [OFFS_W-1:0] v);
		return {{(DATA_W-OFFS_W){v[OFFS_W-1]}}, v};
	endfunction

	function automatic logic reg_in_range(input logic [REG_NUM_W-1:0] r, input int count);
		return int'(r) < count;
	endfunction

endpackage

// File: hdl/mie_if.sv
interface mie_in_if import mie_pkg::*; ;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  func;
	logic [REG_NUM_W-1:0]        dest_or_base;
	logic [REG_NUM_W-1:0]        src_a;
	logic [REG_NUM_W-1:0]        src_b;
	logic signed [OFFS_W-1:0]    mem_offset;
	logic signed [OFFS_W-1:0]    immediate;
	logic [TGT_W-1:0]            branch_target;

	modport source(output valid, func, dest_or_base, src_a, src_b, mem_offset, immediate,
		branch_target, input ready);
	modport sink(input valid, func, dest_or_base, src_a, src_b, mem_offset, immediate,
		branch_target, output ready);
endinterface

interface mie_out_if import mie_pkg::*; ;
	logic                        valid;
	logic                        ready;
	logic [IDX_OUT_W-1:0]        next_index;
	logic                        jumped;
	logic                        reg_written;
	logic [REG_NUM_W-1:0]        write_reg;
	logic signed [DATA_W-1:0]    write_value;
	logic                        address_fault;

	modport source(output valid, next_index, jumped, reg_written, write_reg,
		write_value, address_fault, input ready);
	modport sink(input valid, next_index, jumped, reg_written, write_reg,
		write_value, address_fault, output ready);
endinterface

// File: hdl/mini_isa_execute_unit.sv
// Channel   | Dir | Handshake     | Item
// ----------+-----+---------------+-------------------------------------------
// instr     | in  | valid / ready | one decoded instruction
// result    | out | valid / ready | next index, write-back and fault flags
//
// Throughput one item per cycle unless result.ready is low or the memory sweep
// runs; stage 1 reads the register file, stage 2 is the result register.
// Loads read the data memory between stage 1 and stage 2.
// After reset the data memory is swept to zero, with instr.ready low during
// the sweep. The register file clears at once through valid bits.
// A stalled result holds stage 2 and, when stage 1 is full, stage 1 too.
module mini_isa_execute_unit import mie_pkg::*; #(
	parameter int REG_COUNT  = 32,
	parameter int MEM_BYTES  = 1024,
	parameter int PROG_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	mie_in_if.sink      instr,
	mie_out_if.source   result
);

	localparam int IW = $clog2(PROG_DEPTH);

	// branch target reduced modulo program depth, worked out at elaboration
	typedef logic [IW-1:0] tgt_tab_t [TGT_SPAN];

	function automatic tgt_tab_t build_tgt_tab();
		tgt_tab_t t;
		for (int i = 0; i < TGT_SPAN; i++) begin
			t[i] = IW'(i % PROG_DEPTH);
		end
		return t;
	endfunction

	localparam tgt_tab_t TGT_TAB = build_tgt_tab();

	// ---- handshake / stage control ----
	logic accept;
	logic s1_go;
	logic dm_busy;

	// ---- stage 1: operands coming out of the register file ----
	logic                 s1_valid;
	logic [2:0]           func_s1;
	logic [REG_NUM_W-1:0] rd_s1;
	logic [REG_NUM_W-1:0] rp0_s1;
	logic [REG_NUM_W-1:0] rp1_s1;
	logic [OFFS_W-1:0]    off_s1;
	logic [OFFS_W-1:0]    imm_s1;
	logic [TGT_W-1:0]     tgt_s1;

	// ---- stage 2: result register ----
	logic                 s2_valid;
	logic                 fresh_s2;   // first cycle in stage 2: write-back slot
	logic [IW-1:0]        next_s2;
	logic                 taken_s2;
	logic                 wr_s2;
	logic [REG_NUM_W-1:0] wreg_s2;
	logic [DATA_W-1:0]    wval_s2;
	logic                 load_s2;
	logic                 fault_s2;
	logic [DATA_W-1:0]    wv_s2;

	logic [IW-1:0]        idx_q;

	// register file / memory ports
	rf_wr_t                      rf_wr;
	logic [1:0][REG_NUM_W-1:0]   rf_raddr;
	logic [1:0][DATA_W-1:0]      rf_rdata;
	dm_req_t                     dm_req;
	logic [BYTE_W-1:0]           dm_rdata;

	// stage-1 datapath
	logic [DATA_W-1:0] opa;
	logic [DATA_W-1:0] opb;
	logic [DATA_W-1:0] addr;
	logic              addr_ok;
	logic [IW-1:0]     next_seq;
	logic [IW-1:0]     next_c;
	logic              taken_c;
	logic              wr_c;
	logic              wr_fin;
	logic [DATA_W-1:0] wval_c;
	logic              fault_c;
	logic              load_c;
	logic              store_c;

	// stage 1 moves on when the result register is free or being emptied
	assign s1_go        = s1_valid && (!s2_valid || result.ready);
	assign instr.ready  = !dm_busy && (!s1_valid || s1_go);
	assign accept       = instr.valid && instr.ready;

	// read port 0: base / test / first addend; port 1: store data / second addend
	always_comb begin
		rf_raddr[0] = instr.src_a;
		rf_raddr[1] = instr.src_b;
		if (instr.func == FN_SB || instr.func == FN_BNZ) begin
			rf_raddr[0] = instr.dest_or_base;
		end
		if (instr.func == FN_SB) begin
			rf_raddr[1] = instr.src_a;
		end
	end

	mie_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (rf_wr),
		.rd_en (accept),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	mie_dmem #(
		.MEM_BYTES(MEM_BYTES)
	) u_dmem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dm_req),
		.rdata (dm_rdata),
		.busy  (dm_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= instr.func;
			rd_s1   <= instr.dest_or_base;
			rp0_s1  <= rf_raddr[0];
			rp1_s1  <= rf_raddr[1];
			off_s1  <= instr.mem_offset;
			imm_s1  <= instr.immediate;
			tgt_s1  <= instr.branch_target;
		end
	end

	// write-back value of the item in stage 2 (load data arrives here)
	assign wv_s2 = load_s2 ? sext8(dm_rdata) : wval_s2;

	// forwarding: the item in stage 2 is always the one just before stage 1
	always_comb begin
		opa = rf_rdata[0];
		opb = rf_rdata[1];
		if (s2_valid && wr_s2 && wreg_s2 == rp0_s1) begin
			opa = wv_s2;
		end
		if (s2_valid && wr_s2 && wreg_s2 == rp1_s1) begin
			opb = wv_s2;
		end
	end

	assign addr     = opa + sext16(off_s1);
	assign addr_ok  = addr < DATA_W'(MEM_BYTES);
	assign next_seq = (idx_q == IW'(PROG_DEPTH - 1)) ? '0 : idx_q + 1'b1;

	always_comb begin
		next_c  = next_seq;
		taken_c = 1'b0;
		wr_c    = 1'b0;
		wval_c  = '0;
		fault_c = 1'b0;
		load_c  = 1'b0;
		store_c = 1'b0;
		case (func_s1)
			FN_LB: begin
				load_c  = addr_ok;
				wr_c    = addr_ok;
				fault_c = !addr_ok;
			end
			FN_SB: begin
				store_c = addr_ok;
				fault_c = !addr_ok;
			end
			FN_ADD: begin
				wr_c   = 1'b1;
				wval_c = opa + opb;
			end
			FN_ADDI: begin
				wr_c   = 1'b1;
				wval_c = opa + sext16(imm_s1);
			end
			FN_BNZ: begin
				if (opa != '0) begin
					taken_c = 1'b1;
					next_c  = TGT_TAB[tgt_s1];
				end
			end
			default: begin
			end
		endcase
	end

	// writes to registers past the end of the file are dropped
	assign wr_fin = wr_c && reg_in_range(rd_s1, REG_COUNT);

	always_comb begin
		dm_req.rd_en = s1_go && load_c && wr_fin;
		dm_req.wr_en = s1_go && store_c;
		dm_req.addr  = addr[DADDR_W-1:0];
		dm_req.wdata = opb[BYTE_W-1:0];
	end

	always_comb begin
		rf_wr.en   = fresh_s2 && wr_s2;
		rf_wr.addr = wreg_s2;
		rf_wr.data = wv_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			fresh_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			fresh_s2 <= s1_go;
			if (s1_go) begin
				s2_valid <= 1'b1;
				idx_q    <= next_c;
			end else if (result.ready) begin
				s2_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			next_s2  <= next_c;
			taken_s2 <= taken_c;
			wr_s2    <= wr_fin;
			wreg_s2  <= wr_fin ? rd_s1 : '0;
			wval_s2  <= wr_fin ? wval_c : '0;
			load_s2  <= load_c && wr_fin;
			fault_s2 <= fault_c;
		end
	end

	assign result.valid         = s2_valid;
	assign result.next_index    = IDX_OUT_W'(next_s2);
	assign result.jumped        = taken_s2;
	assign result.reg_written   = wr_s2;
	assign result.write_reg     = wreg_s2;
	assign result.write_value   = wv_s2;
	assign result.address_fault = fault_s2;

endmodule

// File: hdl/mie_regfile.sv
// Register file: two registered read ports, one write port, write-first bypass.
module mie_regfile import mie_pkg::*; #(
	parameter int REG_COUNT = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rf_wr_t                               wr,
	input  logic                                 rd_en,
	input  logic [1:0][REG_NUM_W-1:0]            raddr,
	output logic [1:0][DATA_W-1:0]               rdata
);

	localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	logic [DATA_W-1:0]    mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [1:0][DATA_W-1:0] raw_q;
	logic [1:0][DATA_W-1:0] bypd_q;
	logic [1:0]           ok_q;
	logic [1:0]           byp_q;
	logic                 wr_ok;

	assign wr_ok = wr.en && reg_in_range(wr.addr, REG_COUNT);

	// entries not yet written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[RW'(wr.addr)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[RW'(wr.addr)] <= wr.data;
		end
		if (rd_en) begin
			for (int p = 0; p < 2; p++) begin
				raw_q[p]  <= mem[RW'(raddr[p])];
				ok_q[p]   <= reg_in_range(raddr[p], REG_COUNT) && vld_q[RW'(raddr[p])];
				byp_q[p]  <= wr_ok && (wr.addr == raddr[p]);
				bypd_q[p] <= wr.data;
			end
		end
	end

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			rdata[p] = byp_q[p] ? bypd_q[p] : (ok_q[p] ? raw_q[p] : '0);
		end
	end

endmodule

// File: hdl/mie_dmem.sv
// Byte data memory, registered read, zeroed by a sweep after reset.
module mie_dmem import mie_pkg::*; #(
	parameter int MEM_BYTES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dm_req_t           req,
	output logic [BYTE_W-1:0] rdata,
	output logic              busy
);

	localparam int AW = $clog2(MEM_BYTES);

	logic [BYTE_W-1:0] mem [MEM_BYTES];
	logic [BYTE_W-1:0] rdata_q;
	logic [AW-1:0]     clr_q;
	logic              busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(MEM_BYTES - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: hdl/mie_chk.sv
module mie_chk import mie_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [IDX_OUT_W-1:0] next_index,
	input logic                 jumped,
	input logic                 reg_written,
	input logic [REG_NUM_W-1:0] write_reg,
	input logic [DATA_W-1:0]    write_value,
	input logic                 address_fault
);

	logic [1:0] cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_index)
			&& $stable(write_value) && $stable(write_reg) && $stable(reg_written))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 2'd0)
		else $error("result without an accepted item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_acc || out_acc)
		else $error("more than two items in flight");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_written |-> write_reg == '0 && write_value == '0)
		else $error("write fields set without a register write");

	a_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && address_fault |-> !reg_written && !jumped)
		else $error("fault together with write-back or branch");

endmodule

bind mini_isa_execute_unit mie_chk u_mie_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (instr.valid),
	.in_ready     (instr.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.next_index   (result.next_index),
	.jumped       (result.jumped),
	.reg_written  (result.reg_written),
	.write_reg    (result.write_reg),
	.write_value  (result.write_value),
	.address_fault(result.address_fault)
);
